// ----- hw/rtl/mandelbrot_escape_count_core_defines.svh -----
// assertion macros for the mandelbrot escape counter
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef MANDELBROT_ESCAPE_COUNT_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_COUNT_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mec_pkg.sv -----
// shared constants, types and saturation helper for the escape counter
// no dependencies
package mec_pkg;

  localparam int MaxCount  = 255;
  localparam int FracBits  = 28;
  localparam int IndexBits = 12;
  localparam int WordW     = 32;
  localparam int CountW    = 8;
  localparam int CfgIdxW   = 2;
  localparam int ProdW     = IndexBits + 1 + WordW;
  localparam int SqW       = 2 * WordW;
  localparam int SumW      = 2 * WordW + 2;
  localparam int EscapeLimit = 4;

  localparam logic [CfgIdxW-1:0] RegOriginRe = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOriginIm = 2'd1;
  localparam logic [CfgIdxW-1:0] RegStepRe   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStepIm   = 2'd3;

  localparam logic signed [SumW-1:0] SatHi = SumW'(2**(WordW-1) - 1);
  localparam logic signed [SumW-1:0] SatLo = -SatHi - SumW'(1);

  typedef struct packed {
    logic load;      // capture pixel and form index products
    logic map_add;   // form c, start z at c, clear count
    logic square;    // register the three products of z
    logic step;      // update z and count
    logic out_load;  // move count into the output register
  } cmd_t;

  typedef struct packed {
    logic escape;    // integer part of |z|^2 above the limit
    logic last;      // this step reaches the maximum count
  } status_t;

  function automatic logic signed [WordW-1:0] sat_word(input logic signed [SumW-1:0] v);
    logic signed [WordW-1:0] r;
    r = v[WordW-1:0];
    if (v > SatHi) r = SatHi[WordW-1:0];
    else if (v < SatLo) r = SatLo[WordW-1:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/mandelbrot_escape_count_core.sv -----
// mandelbrot escape-time counter, top level
// uses mec_pkg, mec_ctrl, mec_dpath and the assertion macro header
//
// usage
//   configuration: write origin_real (0), origin_imag (1), step_real (2) and
//   step_imag (3) through cfg_we_i / cfg_idx_i / cfg_data_i while idle; all
//   are signed q4.28 and reset to zero
//   input stream: one transfer per pixel, tdata holds column and row
//   output stream: one transfer per pixel carrying the escape count 0..255
// operation
//   one pixel at a time; after the input transfer the controller maps the
//   pixel, then alternates between registering the three 32x32 products of z
//   and testing for escape while updating z and the count; a pixel that
//   reaches 255 skips the last test; the next pixel can be taken in the cycle
//   after the result is loaded
// reset
//   asynchronous, active low; clears the controller, the output valid flag,
//   the count and the configuration registers
// stalls
//   the result waits in an output register, so the next pixel is taken while
//   it is pending; a finished pixel waits in the controller until the
//   output register frees up, and no new pixel is taken meanwhile
`include "mandelbrot_escape_count_core_defines.svh"

module mandelbrot_escape_count_core import mec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_data_i,
  // pixel input
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [23:0]        s_axis_tdata_i,   // [11:0] column, [23:12] row
  // escape count output
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [7:0]         m_axis_tdata_o    // [7:0] escape_count
);

  cmd_t              cmd;
  status_t           status;
  logic [CountW-1:0] count;
  logic              out_free;

  logic              out_valid_q;
  logic [CountW-1:0] out_data_q;

  // output slot is free if empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready_i;

  mec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mec_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .column_i   (s_axis_tdata_i[IndexBits-1:0]),
    .row_i      (s_axis_tdata_i[2*IndexBits-1:IndexBits]),
    .cmd_i      (cmd),
    .status_o   (status),
    .count_o    (count)
  );

  // output register: valid flag reset, data loaded with the flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_data_q <= count;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // a pixel transfer keeps the block busy on the next cycle
  `MEC_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input taken while busy")
  // a result is never written over one still pending
  `MEC_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_q || m_axis_tready_i, "pending result overwritten")
  // a loaded result shows up as valid
  `MEC_ASSERT_NEXT(a_load_valid, cmd.out_load, m_axis_tvalid_o, "loaded result not presented")

endmodule

// ----- hw/rtl/mec_dpath.sv -----
// datapath: config registers, pixel mapping, z update and count
// depends on mec_pkg
module mec_dpath import mec_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [WordW-1:0]         cfg_data_i,
  input  logic [IndexBits-1:0]     column_i,
  input  logic [IndexBits-1:0]     row_i,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  output logic [CountW-1:0]        count_o
);

  logic signed [WordW-1:0] origin_re_q, origin_im_q, step_re_q, step_im_q;
  logic signed [ProdW-1:0] pr_re_q, pr_im_q;
  logic signed [WordW-1:0] c_re_q, c_im_q, z_re_q, z_im_q;
  logic signed [SqW-1:0]   re_sq_q, im_sq_q, cross_q;
  logic [CountW-1:0]       count_q;

  logic signed [SumW-1:0]  map_re, map_im, diff, cross_x, next_re, next_im;
  logic [SqW-1:0]          mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_re_q <= '0;
      origin_im_q <= '0;
      step_re_q   <= '0;
      step_im_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegOriginRe: origin_re_q <= cfg_data_i;
        RegOriginIm: origin_im_q <= cfg_data_i;
        RegStepRe:   step_re_q   <= cfg_data_i;
        RegStepIm:   step_im_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // mapping: origin plus index times step, saturated once
  assign map_re = SumW'(origin_re_q) + SumW'(pr_re_q);
  assign map_im = SumW'(origin_im_q) + SumW'(pr_im_q);

  // escape test on the exact unsigned sum of squares
  assign mag = SqW'(unsigned'(re_sq_q)) + SqW'(unsigned'(im_sq_q));
  assign status_o.escape = (mag >> (2 * FracBits)) > SqW'(EscapeLimit);
  assign status_o.last   = (count_q == CountW'(MaxCount - 1));

  // floor shifts via arithmetic right shift
  assign diff    = SumW'(re_sq_q) - SumW'(im_sq_q);
  assign cross_x = SumW'(cross_q);
  assign next_re = (diff >>> FracBits) + SumW'(c_re_q);
  assign next_im = (cross_x >>> (FracBits - 1)) + SumW'(c_im_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pr_re_q <= $signed({1'b0, column_i}) * step_re_q;
      pr_im_q <= $signed({1'b0, row_i}) * step_im_q;
    end
    if (cmd_i.map_add) begin
      c_re_q <= sat_word(map_re);
      c_im_q <= sat_word(map_im);
      z_re_q <= sat_word(map_re);
      z_im_q <= sat_word(map_im);
    end else if (cmd_i.step) begin
      z_re_q <= sat_word(next_re);
      z_im_q <= sat_word(next_im);
    end
    if (cmd_i.square) begin
      re_sq_q <= z_re_q * z_re_q;
      im_sq_q <= z_im_q * z_im_q;
      cross_q <= z_re_q * z_im_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.map_add) begin
      count_q <= '0;
    end else if (cmd_i.step) begin
      count_q <= count_q + CountW'(1);
    end
  end

  assign count_o = count_q;

endmodule

// ----- hw/rtl/mec_ctrl.sv -----
// controller state machine sequencing mapping, squaring and update
// depends on mec_pkg
module mec_ctrl import mec_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_free_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMap  = 3'd1;
  localparam logic [2:0] StSq   = 3'd2;
  localparam logic [2:0] StEval = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMap;
        end
      end
      StMap: begin
        cmd_o.map_add = 1'b1;
        state_d       = StSq;
      end
      StSq: begin
        cmd_o.square = 1'b1;
        state_d      = StEval;
      end
      StEval: begin
        if (status_i.escape) begin
          state_d = StFin;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = status_i.last ? StFin : StSq;
        end
      end
      StFin: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ----- dv/mandelbrot_escape_count_core_tb.sv -----
// self-checking testbench for the mandelbrot escape-time counter
// drives pixel transfers and config writes, predicts each escape count
// depends on mec_pkg and mandelbrot_escape_count_core
`timescale 1ns / 100ps

module mandelbrot_escape_count_core_tb;
  import mec_pkg::*;

  localparam int StallLimit = 20000;  // cycles with no transfer before giving up
  localparam int HoldCycles = 3000;   // long receiver back-pressure stretch
  localparam int TailCycles = 600;    // above the worst pixel latency
  localparam int PhaseItems = 140;

  localparam longint WordHi = (longint'(1) <<< (WordW - 1)) - 1;
  localparam longint WordLo = -WordHi - 1;

  typedef struct {
    logic [IndexBits-1:0] column;
    logic [IndexBits-1:0] row;
    logic [CountW-1:0]    count;
  } pixel_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [WordW-1:0]   cfg_data_i = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [23:0]        s_axis_tdata_i = '0;   // [11:0] column, [23:12] row
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [7:0]         m_axis_tdata_o;        // [7:0] escape_count

  // view registers as the block should hold them
  longint origin_re = 0;
  longint origin_im = 0;
  longint step_re = 0;
  longint step_im = 0;

  logic [23:0]   pixel_q[$];       // pixels waiting to be offered
  pixel_result_t pending_counts[$];  // predicted counts, oldest first
  pixel_result_t want;

  int  queued_count = 0;
  int  taken_count = 0;
  int  error_count = 0;
  int  stall_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_left = 0;
  bit  hold_go = 1'b0;
  bit  hold_started = 1'b0;
  bit  pixel_taken = 1'b0;

  mandelbrot_escape_count_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint clamp_word(input longint v);
    if (v > WordHi) return WordHi;
    if (v < WordLo) return WordLo;
    return v;
  endfunction

  // escape-time iteration on the current view, exact products then one clamp
  function automatic logic [CountW-1:0] escape_count_of(input logic [IndexBits-1:0] col,
                                                        input logic [IndexBits-1:0] row);
    longint      c_re, c_im, z_re, z_im, nxt_re, nxt_im;
    logic [63:0] mag;
    c_re = clamp_word(origin_re + longint'(col) * step_re);
    c_im = clamp_word(origin_im + longint'(row) * step_im);
    z_re = c_re;
    z_im = c_im;
    for (int n = 0; n < MaxCount; n++) begin
      // |z|^2 has 2*FracBits fraction bits; only its integer part is tested
      mag = $unsigned(z_re * z_re) + $unsigned(z_im * z_im);
      if ((mag >> (2 * FracBits)) > EscapeLimit) return CountW'(n);
      // arithmetic shifts round toward minus infinity
      nxt_re = clamp_word(((z_re * z_re - z_im * z_im) >>> FracBits) + c_re);
      nxt_im = clamp_word(((z_re * z_im) >>> (FracBits - 1)) + c_im);
      z_re = nxt_re;
      z_im = nxt_im;
    end
    return CountW'(MaxCount);
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  task automatic push_pixel(input int col, input int row);
    pixel_q.push_back({row[IndexBits-1:0], col[IndexBits-1:0]});
    queued_count++;
  endtask

  // every queued pixel taken and every count returned
  task automatic wait_drained();
    do @(negedge clk_i);
    while (taken_count != queued_count || pending_counts.size() != 0);
  endtask

  // write all four view registers, one per cycle, block idle
  task automatic apply_view(input logic [WordW-1:0] o_re, input logic [WordW-1:0] o_im,
                            input logic [WordW-1:0] s_re, input logic [WordW-1:0] s_im);
    logic [WordW-1:0] vals [4];
    vals = '{o_re, o_im, s_re, s_im};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= vals[i];
      case (CfgIdxW'(i))
        RegOriginRe: origin_re = longint'($signed(vals[i]));
        RegOriginIm: origin_im = longint'($signed(vals[i]));
        RegStepRe:   step_re   = longint'($signed(vals[i]));
        RegStepIm:   step_im   = longint'($signed(vals[i]));
        default: ;
      endcase
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // pixel sender: new transfer only once the previous one went through
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || pixel_taken) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pixel_q.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // count receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_go && !hold_started) begin
      hold_started    <= 1'b1;
      hold_left       <= HoldCycles;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // predict on each pixel transfer, check each count transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      pixel_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pending_counts.push_back('{s_axis_tdata_i[11:0], s_axis_tdata_i[23:12],
                                   escape_count_of(s_axis_tdata_i[11:0],
                                                   s_axis_tdata_i[23:12])});
        taken_count++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_counts.size() == 0) begin
          flag_error($sformatf("escape count %0d with no pixel pending", m_axis_tdata_o));
        end else begin
          want = pending_counts.pop_front();
          if (m_axis_tdata_o !== want.count)
            flag_error($sformatf("pixel (%0d,%0d): escape count expected %0d, got %0d",
                                 want.column, want.row, want.count, m_axis_tdata_o));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("mandelbrot_escape_count_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int span_log;
    int step;
    int col;
    int row;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 70;

    // reset view: c is zero everywhere, so nothing escapes
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(12'haaa, 12'h555);
    wait_drained();

    // classic full view, -2 + 1.5i at pixel (0,0), 3/64 per pixel
    apply_view(32'he0000000, 32'h18000000, 32'h00c00000, 32'hff400000);
    push_pixel(0, 32);      // c = -2 exactly, |z|^2 stays at 4 and never exceeds it
    push_pixel(42, 32);     // just left of the origin, inside the set
    push_pixel(63, 0);
    push_pixel(4095, 0);    // real part saturates high
    push_pixel(0, 4095);    // imaginary part saturates low
    push_pixel(32, 48);
    push_pixel(12'h555, 12'haaa);
    push_pixel(12'haaa, 12'h555);
    wait_drained();

    // extreme register values: mapping hits both saturation bounds
    apply_view(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    push_pixel(0, 0);
    push_pixel(1, 1);       // both parts land on -1 lsb, deep inside
    push_pixel(2, 2);       // real part clamps to the lowest word
    push_pixel(4095, 4095);
    wait_drained();

    // finest step along the real axis near the neck of the set
    apply_view(32'hf4000000, 32'h0199999a, 32'h00000001, 32'hffff0000);
    push_pixel(0, 0);
    push_pixel(4095, 0);
    push_pixel(0, 4095);
    push_pixel(2048, 1365);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      // idle pattern moves from receiver-heavy to sender-heavy to none
      if (ph < 2) begin
        send_idle_pct = 31;
        recv_idle_pct = 70;
      end else if (ph < 4) begin
        send_idle_pct = 70;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (ph == 3) begin
        // arbitrary words, mostly large c that escape at once
        apply_view($urandom, $urandom, $urandom, $urandom);
      end else begin
        // random window around the set, zoomed by a random power of two
        span_log = $urandom_range(10);
        step = 3 << (22 - span_log);
        apply_view(int'($urandom_range(738197504)) - 603979776,
                   int'($urandom_range(805306368)) - 402653184,
                   step, ($urandom_range(3) == 0) ? step : -step);
      end

      for (int k = 0; k < PhaseItems; k++) begin
        // mostly inside the window, now and then anywhere in the index range
        col = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(63);
        row = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(63);
        push_pixel(col, row);
      end

      // long hold-off while the sender keeps offering, block backs up
      if (ph == 0) hold_go = 1'b1;

      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && pending_counts.size() == 0)
      $display("mandelbrot_escape_count_core: match");
    else
      $display("mandelbrot_escape_count_core: mismatch");
    $finish;
  end

endmodule
